[src/tgbp_pkg.sv]
// Shared types, constants and hash helpers of the tagged geometric branch predictor.
`timescale 1ns / 1ps

package tgbp_pkg;

  // Default geometry
  localparam int TABLE_ENTRIES_DEF     = 1024;
  localparam int NUM_TAGGED_TABLES_DEF = 4;
  localparam int COUNTER_WIDTH_DEF     = 3;
  localparam int USEFUL_WIDTH_DEF      = 2;
  localparam int TAG_WIDTH_DEF         = 8;

  // Hash constants
  localparam logic [63:0] HASH_ADD = 64'h0000_0000_9e37_79b9;
  localparam logic [63:0] TAG_SEED = 64'h00dc_c979_7bb5_83d4;
  // Constant part of the tag seed combine: HASH_ADD + (seed << 6) + (seed >> 2)
  localparam logic [63:0] TAG_ADD  = HASH_ADD + (TAG_SEED << 6) + (TAG_SEED >> 2);

  // Choice LFSR
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // Periodic useful clearing
  localparam int          COUNT_W      = 24;
  localparam int          PERIOD_W     = 5;
  localparam logic [4:0]  PERIOD_RESET = 5'd18;
  localparam logic [4:0]  PERIOD_MIN   = 5'd1;
  localparam logic [4:0]  PERIOD_MAX   = 5'd24;

  typedef struct packed {
    logic [63:0] branch_address;
    logic        outcome_taken;
  } branch_t;

  typedef struct packed {
    logic       predicted_taken;
    logic [2:0] provider_table;
    logic       mispredicted;
  } result_t;

  // Low 16 bits of x ^= x>>32; x ^= x>>16
  function automatic logic [15:0] fold16(logic [63:0] x);
    return x[15:0] ^ x[31:16] ^ x[47:32] ^ x[63:48];
  endfunction

  // Remainder by 3: base-4 digit sum, then reciprocal multiply on 5 bits
  function automatic logic [1:0] mod3(logic [15:0] x);
    logic [4:0] s;
    logic [8:0] q;
    logic [4:0] r;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(x[2*i +: 2]);
    end
    q = (9'(s) * 9'd11) >> 5;
    r = s - 5'(q[3:0] * 4'd3);
    return r[1:0];
  endfunction

endpackage

[src/tagged_geometric_branch_predictor_core.sv]
// Tagged geometric-history branch predictor: hashing, table banks and update sequencer.
//
// Channel  Dir  Handshake              Payload
// in       in   in_valid_i/in_ready_o   in_data_i  (branch_t)
// out      out  out_valid_o/out_ready_i out_data_o (result_t)
// cfg      in   cfg_we_i               cfg_data_i (useful reset period, log2)
//
// Each item passes through accept, hash, bank read, evaluate and write-back,
// in that order; a new item is accepted only once the last one is through.
// All tables sit in single-read, single-write memories.
// After reset a clearing pass over every table entry runs before the first item.
// A periodic useful clearing sweeps every entry after evaluating the item that hits it.
// A result waiting on out_ready_i holds the item in write-back.
`timescale 1ns / 1ps

module tagged_geometric_branch_predictor_core
  import tgbp_pkg::*;
#(
  parameter int TABLE_ENTRIES     = TABLE_ENTRIES_DEF,
  parameter int NUM_TAGGED_TABLES = NUM_TAGGED_TABLES_DEF,
  parameter int COUNTER_WIDTH     = COUNTER_WIDTH_DEF,
  parameter int USEFUL_WIDTH      = USEFUL_WIDTH_DEF,
  parameter int TAG_WIDTH         = TAG_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  branch_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output result_t             out_data_o,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_data_i
);

  localparam int NT     = NUM_TAGGED_TABLES;
  localparam int CW     = COUNTER_WIDTH;
  localparam int UW     = USEFUL_WIDTH;
  localparam int TW     = TAG_WIDTH;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int HIST_W = 1 << (NT - 1);
  localparam int PROV_W = $clog2(NT + 1);

  localparam logic [CW-1:0]    CTR_MID  = CW'(1 << (CW - 1));
  localparam logic [CW-1:0]    CTR_MAX  = CW'((1 << CW) - 1);
  localparam logic [UW-1:0]    USE_MAX  = UW'((1 << UW) - 1);
  localparam logic [UW-1:0]    KEEP_HI  = USE_MAX >> 1;
  localparam logic [UW-1:0]    KEEP_LO  = USE_MAX & ~UW'(1);
  localparam logic [PROV_W-1:0] BASE_CODE = PROV_W'(NT);
  localparam logic [IDX_W:0]   SWP_END  = (IDX_W + 1)'(TABLE_ENTRIES);
  localparam logic [IDX_W:0]   SWP_LAST = (IDX_W + 1)'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_HASH, S_READ, S_EVAL, S_CLR, S_WB
  } state_e;

  // Newest 2^c history bits, folded to 64 bits by word xor
  function automatic logic [63:0] hist_fold(logic [HIST_W-1:0] h, int c);
    logic [63:0] r;
    r = '0;
    for (int j = 0; j < HIST_W; j++) begin
      if (j < (1 << c)) r[j % 64] = r[j % 64] ^ h[j];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Registers
  state_e              state_q;
  logic [IDX_W:0]      swp_q;
  logic [PERIOD_W-1:0] period_q;
  logic [HIST_W-1:0]   hist_q;
  logic [COUNT_W-1:0]  count_q;
  logic                clr_hi_q;
  logic [15:0]         lfsr_q;
  logic [UW-1:0]       keep_q;
  logic                out_valid_q;
  result_t             out_data_q;

  // Item pipeline payload
  logic [63:0]         sa_q, st_q, bi_q, bt_q;
  logic [IDX_W-1:0]    bidx_q;
  logic                taken_q;
  logic [IDX_W-1:0]    idx_q [NT];
  logic [TW-1:0]       tag_q [NT];

  // Write-back plan
  logic [CW-1:0]       ctr_w_q [NT];
  logic [UW-1:0]       use_w_q [NT];
  logic [TW-1:0]       tag_w_q [NT];
  logic [CW-1:0]       base_w_q;
  result_t             res_q;

  // Memories and read data
  logic [CW-1:0] ctr_mem  [NT][TABLE_ENTRIES];
  logic [UW-1:0] use_mem  [NT][TABLE_ENTRIES];
  logic [TW-1:0] tag_mem  [NT][TABLE_ENTRIES];
  logic [CW-1:0] base_mem [TABLE_ENTRIES];
  logic [CW-1:0] ctr_rd [NT];
  logic [UW-1:0] use_rd [NT];
  logic [TW-1:0] tag_rd [NT];
  logic [CW-1:0] base_rd;

  logic wb_go;
  assign wb_go       = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------
  // Per-table index and tag hashes
  logic [IDX_W-1:0] idx_c [NT];
  logic [TW-1:0]    tag_c [NT];

  always_comb begin
    logic [63:0] hv;
    logic [15:0] fi, ft;
    for (int c = 0; c < NT; c++) begin
      hv = hist_fold(hist_q, c);
      fi = fold16(sa_q ^ (bi_q + hv));
      ft = fold16(st_q ^ (bt_q + hv));
      idx_c[c] = fi[IDX_W-1:0];
      tag_c[c] = ft[TW-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Memory ports
  logic [IDX_W-1:0] raddr [NT];
  logic [IDX_W-1:0] waddr;
  logic [IDX_W:0]   swp_prev;
  logic             we_all, we_use;

  assign swp_prev = swp_q - 1'b1;

  always_comb begin
    for (int c = 0; c < NT; c++) begin
      raddr[c] = (state_q == S_CLR) ? swp_q[IDX_W-1:0] : idx_c[c];
    end
    we_all = (state_q == S_INIT) || (state_q == S_WB && wb_go);
    we_use = (state_q == S_CLR) && (swp_q != '0);
    waddr  = swp_q[IDX_W-1:0];
    if (state_q == S_CLR) waddr = swp_prev[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NT; c++) begin
      if (we_all) begin
        if (state_q == S_INIT) begin
          ctr_mem[c][waddr] <= CTR_MID;
          use_mem[c][waddr] <= '0;
          tag_mem[c][waddr] <= '0;
        end else begin
          ctr_mem[c][idx_q[c]] <= ctr_w_q[c];
          use_mem[c][idx_q[c]] <= use_w_q[c];
          tag_mem[c][idx_q[c]] <= tag_w_q[c];
        end
      end else if (we_use) begin
        use_mem[c][waddr] <= use_rd[c] & keep_q;
      end
      ctr_rd[c] <= ctr_mem[c][raddr[c]];
      use_rd[c] <= use_mem[c][raddr[c]];
      tag_rd[c] <= tag_mem[c][raddr[c]];
    end
    if (state_q == S_INIT) begin
      base_mem[waddr] <= CTR_MID;
    end else if (state_q == S_WB && wb_go) begin
      base_mem[bidx_q] <= base_w_q;
    end
    base_rd <= base_mem[bidx_q];
  end

  // ---------------------------------------------------------------
  // Prediction and update plan
  logic [CW-1:0]      ctr_n [NT];
  logic [UW-1:0]      use_n [NT];
  logic [TW-1:0]      tag_n [NT];
  logic [UW-1:0]      u_m   [NT];
  logic [CW-1:0]      base_n, prov_ctr, alt_ctr;
  logic [PROV_W-1:0]  prov, first, second, pick;
  logic               found, alt_found, have_first, have_second;
  logic               pred, mis, disagree, clr_hit;
  logic [COUNT_W-1:0] count_inc, count_n, per_mask;
  logic [PERIOD_W-1:0] per;
  logic [15:0]        lfsr_step, lfsr_n;
  logic [UW-1:0]      keep;

  always_comb begin
    // provider: longest matching table, alternate: next matching one
    found = 1'b0;  alt_found = 1'b0;
    prov = BASE_CODE;
    prov_ctr = '0; alt_ctr = '0;
    for (int c = NT - 1; c >= 0; c--) begin
      if (tag_rd[c] == tag_q[c]) begin
        if (!found) begin
          found = 1'b1;
          prov = PROV_W'(c);
          prov_ctr = ctr_rd[c];
        end else if (!alt_found) begin
          alt_found = 1'b1;
          alt_ctr = ctr_rd[c];
        end
      end
    end
    pred     = found ? prov_ctr[CW-1] : base_rd[CW-1];
    mis      = pred != taken_q;
    disagree = found && alt_found && (prov_ctr[CW-1] != alt_ctr[CW-1]);

    // periodic clearing check
    per = period_q;
    if (per < PERIOD_MIN) per = PERIOD_MIN;
    if (per > PERIOD_MAX) per = PERIOD_MAX;
    count_inc = count_q + 1'b1;
    per_mask  = (COUNT_W'(1) << per) - 1'b1;
    clr_hit   = (count_inc & per_mask) == '0;
    count_n   = clr_hit ? '0 : count_inc;
    keep      = clr_hi_q ? KEEP_HI : KEEP_LO;

    for (int c = 0; c < NT; c++) begin
      u_m[c]   = clr_hit ? (use_rd[c] & keep) : use_rd[c];
      ctr_n[c] = ctr_rd[c];
      use_n[c] = u_m[c];
      tag_n[c] = tag_rd[c];
    end
    base_n = base_rd;

    // allocation candidates above the provider
    have_first = 1'b0; have_second = 1'b0;
    first = BASE_CODE; second = BASE_CODE;
    for (int c = 0; c < NT; c++) begin
      if ((!found || c > prov) && u_m[c] == '0) begin
        if (!have_first) begin
          have_first = 1'b1;
          first = PROV_W'(c);
        end else if (!have_second) begin
          have_second = 1'b1;
          second = PROV_W'(c);
        end
      end
    end
    lfsr_step = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 16'h0000);
    lfsr_n = lfsr_q;
    pick   = first;

    if (!mis) begin
      for (int c = 0; c < NT; c++) begin
        if (disagree && PROV_W'(c) == prov && u_m[c] != USE_MAX) use_n[c] = u_m[c] + 1'b1;
      end
    end else begin
      if (!have_first) begin
        for (int c = 0; c < NT; c++) begin
          if ((!found || c > prov) && u_m[c] != '0) use_n[c] = u_m[c] - 1'b1;
        end
      end else begin
        if (have_second) begin
          lfsr_n = lfsr_step;
          if (mod3(lfsr_step) == 2'd0) pick = second;
        end
        for (int c = 0; c < NT; c++) begin
          if (PROV_W'(c) == pick) begin
            ctr_n[c] = CTR_MID - CW'(!taken_q);
            use_n[c] = '0;
            tag_n[c] = tag_q[c];
          end
        end
      end
      for (int c = 0; c < NT; c++) begin
        if (disagree && PROV_W'(c) == prov && u_m[c] != '0) use_n[c] = u_m[c] - 1'b1;
      end
    end

    // train the providing counter
    if (found) begin
      for (int c = 0; c < NT; c++) begin
        if (PROV_W'(c) == prov) begin
          if (taken_q && ctr_rd[c] != CTR_MAX) ctr_n[c] = ctr_rd[c] + 1'b1;
          if (!taken_q && ctr_rd[c] != '0) ctr_n[c] = ctr_rd[c] - 1'b1;
        end
      end
    end else begin
      if (taken_q && base_rd != CTR_MAX) base_n = base_rd + 1'b1;
      if (!taken_q && base_rd != '0) base_n = base_rd - 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // Sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      swp_q       <= '0;
      period_q    <= PERIOD_RESET;
      hist_q      <= '0;
      count_q     <= '0;
      clr_hi_q    <= 1'b1;
      lfsr_q      <= LFSR_SEED;
      keep_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) period_q <= cfg_data_i;
      // write-back sets valid itself
      if (out_valid_q && out_ready_i && state_q != S_WB) out_valid_q <= 1'b0;

      case (state_q)
        S_INIT: begin
          if (swp_q == SWP_LAST) begin
            swp_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            swp_q <= swp_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            sa_q    <= in_data_i.branch_address + HASH_ADD;
            st_q    <= TAG_SEED ^ (in_data_i.branch_address + TAG_ADD);
            bidx_q  <= IDX_W'(fold16(in_data_i.branch_address));
            taken_q <= in_data_i.outcome_taken;
            state_q <= S_HASH;
          end
        end
        S_HASH: begin
          bi_q    <= HASH_ADD + (sa_q << 6) + (sa_q >> 2);
          bt_q    <= HASH_ADD + (st_q << 6) + (st_q >> 2);
          state_q <= S_READ;
        end
        S_READ: begin
          for (int c = 0; c < NT; c++) begin
            idx_q[c] <= idx_c[c];
            tag_q[c] <= tag_c[c];
          end
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          for (int c = 0; c < NT; c++) begin
            ctr_w_q[c] <= ctr_n[c];
            use_w_q[c] <= use_n[c];
            tag_w_q[c] <= tag_n[c];
          end
          base_w_q               <= base_n;
          res_q.predicted_taken  <= pred;
          res_q.provider_table   <= 3'(prov);
          res_q.mispredicted     <= mis;
          count_q                <= count_n;
          lfsr_q                 <= lfsr_n;
          keep_q                 <= keep;
          swp_q                  <= '0;
          if (clr_hit) begin
            clr_hi_q <= !clr_hi_q;
            state_q  <= S_CLR;
          end else begin
            state_q  <= S_WB;
          end
        end
        S_CLR: begin
          swp_q <= swp_q + 1'b1;
          if (swp_q == SWP_END) state_q <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            hist_q      <= {hist_q[HIST_W-2:0], taken_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  a_accept_to_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_HASH))
    else $error("accepted item did not enter hashing");

  a_wb_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && wb_go) |=> (out_valid_q && state_q == S_IDLE))
    else $error("write-back did not present a result");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> (swp_q <= SWP_END))
    else $error("useful clearing sweep overran the table");

  a_clear_only_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR && swp_q == '0) |-> ($past(state_q) == S_EVAL && count_q == '0))
    else $error("useful clearing started without a period hit");

endmodule

[tb/tb.sv]
// Self-checking testbench for the tagged geometric branch predictor core.
`timescale 1ns / 1ps

module tb;
  import tgbp_pkg::*;

  localparam int ENTRIES  = TABLE_ENTRIES_DEF;
  localparam int NTAB     = NUM_TAGGED_TABLES_DEF;
  localparam int BASE_TBL = NUM_TAGGED_TABLES_DEF;
  localparam int CTR_W    = COUNTER_WIDTH_DEF;
  localparam int USE_W    = USEFUL_WIDTH_DEF;
  localparam logic [CTR_W-1:0] CTR_MID = CTR_W'(1 << (CTR_W - 1));
  localparam logic [CTR_W-1:0] CTR_TOP = CTR_W'((1 << CTR_W) - 1);
  localparam logic [USE_W-1:0] USE_TOP = USE_W'((1 << USE_W) - 1);
  localparam int HOLD_CYCLES = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  branch_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  result_t             out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [PERIOD_W-1:0] cfg_data_i = '0;

  // Shadow predictor state
  logic [CTR_W-1:0]     base_ctr [ENTRIES];
  logic [CTR_W-1:0]     tag_ctr  [NTAB][ENTRIES];
  logic [USE_W-1:0]     useful   [NTAB][ENTRIES];
  logic [TAG_WIDTH_DEF-1:0] tags [NTAB][ENTRIES];
  logic [7:0]           ghist;
  logic [COUNT_W-1:0]   br_count;
  logic                 clear_hi;
  logic [15:0]          lfsr;
  logic [PERIOD_W-1:0]  period;

  result_t     pending_q[$];
  int          errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic [63:0] addr_pool [16];

  // Receiver hold-off
  logic hold_tgl = 1'b0, hold_seen = 1'b0;
  int   hold_cnt = 0;

  tagged_geometric_branch_predictor_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #(50_000_000);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [63:0] xfold(logic [63:0] x);
    logic [63:0] y;
    y = x ^ (x >> 32);
    return y ^ (y >> 16);
  endfunction

  function automatic logic [63:0] mix(logic [63:0] s, logic [63:0] v);
    return s ^ (v + HASH_ADD + (s << 6) + (s >> 2));
  endfunction

  function automatic void shadow_reset();
    for (int t = 0; t < NTAB; t++) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tag_ctr[t][i] = CTR_MID;
        useful[t][i]  = '0;
        tags[t][i]    = '0;
      end
    end
    for (int i = 0; i < ENTRIES; i++) base_ctr[i] = CTR_MID;
    ghist = '0;
    br_count = '0;
    clear_hi = 1'b1;
    lfsr = LFSR_SEED;
    period = PERIOD_RESET;
  endfunction

  // Predict, then train the shadow tables exactly as the core should
  function automatic result_t shadow_branch(branch_t b);
    int idx[NTAB];
    logic [TAG_WIDTH_DEF-1:0] tg[NTAB];
    int prov, alt, bidx, s, first, second, pick, p;
    logic [63:0] h, x;
    logic pred, tk, disagree, lsb;
    logic [USE_W-1:0] keep;
    logic [COUNT_W-1:0] cmask;
    result_t r;
    tk = b.outcome_taken;
    prov = BASE_TBL;
    alt = BASE_TBL;
    bidx = int'(xfold(b.branch_address) % ENTRIES);
    for (int c = 0; c < NTAB; c++) begin
      h = 64'(ghist & 8'((1 << (1 << c)) - 1));
      x = mix(mix(64'd0, b.branch_address), h);
      idx[c] = int'(xfold(x) % ENTRIES);
      x = mix(mix(TAG_SEED, b.branch_address), h);
      x = xfold(x);
      tg[c] = x[TAG_WIDTH_DEF-1:0];
    end
    // longest match provides, next match is the alternate
    for (int c = NTAB - 1; c >= 0; c--) begin
      if (tags[c][idx[c]] == tg[c]) begin
        if (prov == BASE_TBL) prov = c;
        else if (alt == BASE_TBL) alt = c;
      end
    end
    pred = (prov == BASE_TBL) ? base_ctr[bidx][CTR_W-1] : tag_ctr[prov][idx[prov]][CTR_W-1];

    // periodic useful clearing
    p = int'(period);
    if (p < 1) p = 1;
    if (p > 24) p = 24;
    br_count = br_count + 1'b1;
    cmask = COUNT_W'((1 << p) - 1);
    if ((br_count & cmask) == '0) begin
      keep = clear_hi ? (USE_TOP >> 1) : (USE_TOP & ~USE_W'(1));
      for (int t = 0; t < NTAB; t++)
        for (int i = 0; i < ENTRIES; i++) useful[t][i] &= keep;
      clear_hi = ~clear_hi;
      br_count = '0;
    end

    disagree = prov != BASE_TBL && alt != BASE_TBL &&
               tag_ctr[prov][idx[prov]][CTR_W-1] != tag_ctr[alt][idx[alt]][CTR_W-1];
    if (tk == pred) begin
      if (disagree && useful[prov][idx[prov]] < USE_TOP) useful[prov][idx[prov]]++;
    end else begin
      s = (prov != BASE_TBL) ? prov + 1 : 0;
      first = BASE_TBL;
      second = BASE_TBL;
      for (int c = s; c < NTAB; c++) begin
        if (useful[c][idx[c]] == '0 && second == BASE_TBL) begin
          if (first == BASE_TBL) first = c;
          else second = c;
        end
      end
      if (first == BASE_TBL) begin
        // nothing free: age the longer entries
        for (int c = s; c < NTAB; c++)
          if (useful[c][idx[c]] != '0) useful[c][idx[c]]--;
      end else begin
        pick = first;
        if (second != BASE_TBL) begin
          lsb = lfsr[0];
          lfsr = lfsr >> 1;
          if (lsb) lfsr ^= LFSR_TAPS;
          if (lfsr % 3 == 0) pick = second;
        end
        tag_ctr[pick][idx[pick]] = tk ? CTR_MID : CTR_MID - 1'b1;
        useful[pick][idx[pick]]  = '0;
        tags[pick][idx[pick]]    = tg[pick];
      end
      if (disagree && useful[prov][idx[prov]] != '0) useful[prov][idx[prov]]--;
    end

    // train the providing counter
    if (prov == BASE_TBL) begin
      if (tk && base_ctr[bidx] != CTR_TOP) base_ctr[bidx]++;
      else if (!tk && base_ctr[bidx] != '0) base_ctr[bidx]--;
    end else begin
      if (tk && tag_ctr[prov][idx[prov]] != CTR_TOP) tag_ctr[prov][idx[prov]]++;
      else if (!tk && tag_ctr[prov][idx[prov]] != '0) tag_ctr[prov][idx[prov]]--;
    end
    ghist = {ghist[6:0], tk};

    r.predicted_taken = pred;
    r.provider_table  = 3'(prov);
    r.mispredicted    = pred != tk;
    return r;
  endfunction

  // Result checker and receiver stalls
  always @(posedge clk_i) begin
    result_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result with no expected item: %p", out_data_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_data_o.predicted_taken !== e.predicted_taken) begin
          $error("predicted_taken exp %0d got %0d", e.predicted_taken,
                 out_data_o.predicted_taken);
          errors++;
        end
        if (out_data_o.provider_table !== e.provider_table) begin
          $error("provider_table exp %0d got %0d", e.provider_table,
                 out_data_o.provider_table);
          errors++;
        end
        if (out_data_o.mispredicted !== e.mispredicted) begin
          $error("mispredicted exp %0d got %0d", e.mispredicted, out_data_o.mispredicted);
          errors++;
        end
      end
    end
    out_ready_i <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_cnt  <= HOLD_CYCLES;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Offer one branch item; valid stays up if the next item follows at once
  task automatic send_branch(input logic [63:0] a, input logic tk);
    branch_t b;
    b.branch_address = a;
    b.outcome_taken  = tk;
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_q.push_back(shadow_branch(b));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    period = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Mostly recurring branches with biased or loop-like outcomes, some one-off noise
  task automatic send_mixed(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(15);
      if ($urandom_range(99) < 15)
        send_branch(rand_addr(), 1'($urandom));
      else if (k < 8)
        send_branch(addr_pool[k], ($urandom_range(99) < 85) ? k[0] : ~k[0]);
      else
        send_branch(addr_pool[k], (i % (k - 5)) != 0);
    end
  endtask

  task automatic test_directed();
    send_branch(64'h0, 1'b0);
    send_branch(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_branch(64'h5555_5555_5555_5555, 1'b0);
    send_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_branch(64'h8000_0000_0000_0000, 1'b0);
    // one branch flipping: allocation, alternate disagreement, no free entry
    for (int i = 0; i < 12; i++) send_branch(64'h0000_0000_0040_1000, i[0]);
    for (int i = 0; i < 6; i++) send_branch(64'hFFFF_FFFF_FFFF_FFFF, i < 3);
    drain();
  endtask

  // Period extremes, including the out-of-range ones
  task automatic test_period_extremes();
    logic [PERIOD_W-1:0] vals[5] = '{5'd0, 5'd1, 5'd31, 5'd24, 5'd2};
    foreach (vals[j]) begin
      write_period(vals[j]);
      send_mixed(10);
      drain();
    end
  endtask

  task automatic test_random(input int n, input int ip, input int sp);
    idle_pct  = ip;
    stall_pct = sp;
    send_mixed(n);
    drain();
  endtask

  // Receiver holds off while items keep coming, then a full pause
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_tgl = ~hold_tgl;
    send_mixed(40);
    drain();
    send_mixed(20);
    drain();
  endtask

  initial begin
    foreach (addr_pool[i]) addr_pool[i] = rand_addr();
    shadow_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_period_extremes();
    write_period(5'd8);
    test_random(330, 0, 0);
    test_random(330, 80, 0);
    test_random(330, 0, 80);
    write_period(5'd6);
    test_random(330, 36, 36);
    test_backpressure();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
